// ----- rtl/pkt_pkg.sv -----
// Shared constants, codes and types for the pressed-key table.
`default_nettype none

package pkt_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int KEY_W       = 16;
  localparam int OP_W        = 3;
  localparam int ACT_W       = 2;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [OP_W-1:0]  op_t;
  typedef logic [ACT_W-1:0] act_t;

  localparam op_t OP_PRESS       = 3'd0;
  localparam op_t OP_HOLD        = 3'd1;
  localparam op_t OP_RELEASE     = 3'd2;
  localparam op_t OP_TOGGLE      = 3'd3;
  localparam op_t OP_RELEASE_ALL = 3'd4;

  localparam act_t ACT_PRESS       = 2'd0;
  localparam act_t ACT_RELEASE     = 2'd1;
  localparam act_t ACT_RELEASE_ALL = 2'd2;

  // Carried from each cell to the next one up the row.
  typedef struct packed {
    logic found;       // the key sits in this slot or a lower one
    logic empty_seen;  // an empty slot was seen at this slot or a lower one
  } chain_t;

  // Update command broadcast to every cell for one event.
  typedef struct packed {
    logic add;
    logic remove;
    logic clear;
  } cell_cmd_t;

endpackage : pkt_pkg

`default_nettype wire

// ----- rtl/pressed_key_table.sv -----
// Top level of the pressed-key table: cell row, event decode and result register.
//
// The input channel (in_valid, in_stall, op, key) carries one key event per
// transaction. The output channel (out_valid, out_stall, action, key_out,
// stored, dropped) carries the host action that the event causes. Release-all
// ignores key; an unknown op code is accepted and dropped with no result.
//
// Each slot of the table is a cell in a row. A found flag and a first-empty
// flag ripple up the row in the cycle the event is accepted, the table is
// updated at that edge, and the result is captured in the output register at
// the same edge. One event is accepted every cycle while in_stall is low; the
// compare and shift across the row of TABLE_DEPTH cells are combinational.
//
// When the receiver stalls, the result waits in the output register and
// in_stall is raised, so a new event is taken in the same cycle the held
// result leaves. Reset (rst, synchronous) empties the table and the output
// register; there is no clearing pass.
`default_nettype none

module pressed_key_table (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pkt_pkg::op_t  op,
  input  wire pkt_pkg::key_t key,
  output logic               out_valid,
  input  wire logic          out_stall,
  output pkt_pkg::act_t      action,
  output pkt_pkg::key_t      key_out,
  output logic               stored,
  output logic               dropped
);
  import pkt_pkg::*;

  chain_t    chain [TABLE_DEPTH+1];
  key_t      slot_q [TABLE_DEPTH];
  key_t      upper [TABLE_DEPTH];
  cell_cmd_t cmd;
  logic      accept;
  logic      known_op;
  logic      found_any;
  logic      full;
  logic      key_nz;
  logic      out_valid_next;
  act_t      act_c;
  logic      stored_c;
  logic      dropped_c;
  logic [TABLE_DEPTH-1:0] empty_vec;

  assign chain[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_top
      assign upper[i] = '0;
    end else begin : g_mid
      assign upper[i] = slot_q[i+1];
    end

    pkt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .key        (key),
      .cmd        (cmd),
      .chain_in   (chain[i]),
      .upper_slot (upper[i]),
      .chain_out  (chain[i+1]),
      .slot       (slot_q[i])
    );

    assign empty_vec[i] = (slot_q[i] == '0);
  end

  assign found_any = chain[TABLE_DEPTH].found;
  assign full      = !chain[TABLE_DEPTH].empty_seen;
  assign key_nz    = (key != '0);
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & !in_stall;

  always_comb begin
    known_op  = 1'b1;
    act_c     = ACT_PRESS;
    stored_c  = 1'b0;
    dropped_c = 1'b0;
    cmd       = '0;
    case (op)
      OP_PRESS, OP_HOLD: begin
        cmd.add   = !found_any;
        stored_c  = key_nz && (found_any || !full);
        dropped_c = key_nz && !found_any && full;
      end
      OP_RELEASE: begin
        act_c      = ACT_RELEASE;
        cmd.remove = 1'b1;
      end
      OP_TOGGLE: begin
        if (found_any) begin
          act_c      = ACT_RELEASE;
          cmd.remove = 1'b1;
        end else begin
          cmd.add   = 1'b1;
          stored_c  = key_nz && !full;
          dropped_c = key_nz && full;
        end
      end
      OP_RELEASE_ALL: begin
        act_c     = ACT_RELEASE_ALL;
        cmd.clear = 1'b1;
      end
      default: begin
        known_op = 1'b0;
      end
    endcase
    // Key zero never matches and is never stored.
    cmd.add    = cmd.add & accept & key_nz;
    cmd.remove = cmd.remove & accept;
    cmd.clear  = cmd.clear & accept;
  end

  assign out_valid_next = (accept & known_op) | in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && known_op) begin
      action  <= act_c;
      key_out <= (act_c == ACT_RELEASE_ALL) ? key_t'(0) : key;
      stored  <= stored_c;
      dropped <= dropped_c;
    end
  end

  // Stored keys stay packed at the bottom of the table.
  a_compact: assert property (@(posedge clk) disable iff (rst)
    (empty_vec & ~{1'b1, empty_vec[TABLE_DEPTH-1:1]}) == '0)
    else $error("empty slot below a stored key");

  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_RELEASE_ALL |=> empty_vec == '1)
    else $error("table not empty after release all");

  a_drop_press: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> action == ACT_PRESS && !stored && key_out != '0)
    else $error("dropped flag on a result that is not a refused press");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    accept && dropped_c |-> empty_vec == '0)
    else $error("press dropped while a slot was free");

  a_release_gone: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_RELEASE |=> !out_valid || !stored)
    else $error("key reported stored after its release");

endmodule : pressed_key_table

`default_nettype wire

// ----- rtl/pkt_cell.sv -----
// One slot of the key table with its compare and shift logic.
`default_nettype none

module pkt_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pkt_pkg::key_t      key,
  input  wire pkt_pkg::cell_cmd_t cmd,
  input  wire pkt_pkg::chain_t    chain_in,
  input  wire pkt_pkg::key_t      upper_slot,
  output pkt_pkg::chain_t         chain_out,
  output pkt_pkg::key_t           slot
);
  import pkt_pkg::*;

  logic match;
  logic empty;
  key_t slot_next;

  assign match = (slot == key) && (key != '0);
  assign empty = (slot == '0);

  assign chain_out.found      = chain_in.found | match;
  assign chain_out.empty_seen = chain_in.empty_seen | empty;

  always_comb begin
    slot_next = slot;
    if (cmd.clear) begin
      slot_next = '0;
    end else if (cmd.remove && chain_out.found) begin
      // Everything at and above the removed key moves down one slot.
      slot_next = upper_slot;
    end else if (cmd.add && empty && !chain_in.empty_seen) begin
      slot_next = key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else begin
      slot <= slot_next;
    end
  end

endmodule : pkt_cell

`default_nettype wire
